### hw/rtl/swt_pkg.sv
// swt_pkg: shared types and constants for the stopwatch/timer core.
// Opcodes, event kinds, register indexes and clock limits.
// No dependencies.
package swt_pkg;

  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;
  localparam logic [1:0] OP_RUN  = 2'd3;

  localparam logic [2:0] EVT_NONE   = 3'd0;
  localparam logic [2:0] EVT_SLOW   = 3'd1;
  localparam logic [2:0] EVT_HELD   = 3'd2;
  localparam logic [2:0] EVT_PRESS  = 3'd3;
  localparam logic [2:0] EVT_REPEAT = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_COUNT_DOWN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TGT_HOURS  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TGT_MINS   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TGT_SECS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TGT_HUNDS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RPT_WAIT   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_RPT_PERIOD = 3'd7;

  localparam logic [6:0] DEBOUNCE_RST   = 7'd5;
  localparam logic [7:0] RPT_WAIT_RST   = 8'd125;
  localparam logic [7:0] RPT_PERIOD_RST = 8'd25;

  // wrap limits (compare with >=) and borrow reload values
  localparam logic [7:0] HUNDS_LIM = 8'd100;
  localparam logic [6:0] SECS_LIM  = 7'd60;
  localparam logic [6:0] MINS_LIM  = 7'd60;
  localparam logic [5:0] HOURS_LIM = 6'd24;
  localparam logic [6:0] HUNDS_MAX = 7'd99;
  localparam logic [5:0] SECS_MAX  = 6'd59;
  localparam logic [5:0] MINS_MAX  = 6'd59;
  localparam logic [4:0] HOURS_MAX = 5'd23;

  typedef struct packed {
    logic [6:0] debounce_ticks;
    logic [7:0] repeat_wait;
    logic [7:0] repeat_period;
  } key_cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] keys;
  } key_evt_t;

endpackage

### hw/rtl/swt_debounce.sv
// swt_debounce: three-key debouncer with held, press and long-repeat events.
// Holds the stable counter, last sample and the pending key event.
// Depends on swt_pkg.
module swt_debounce (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  input  logic               consume_i,
  input  logic [2:0]         key_pins_i,
  input  swt_pkg::key_cfg_t  cfg_i,
  output swt_pkg::key_evt_t  pend_o
);

  logic [7:0]        cnt_q, cnt_d;
  logic [2:0]        last_q, last_d;
  swt_pkg::key_evt_t pend_q, pend_d;

  logic [2:0] key;
  logic [7:0] cnt_inc;
  logic [8:0] rpt_sum;
  logic [8:0] reload;

  always_comb begin
    key     = ~key_pins_i;
    cnt_inc = cnt_q + 8'd1;
    rpt_sum = {2'b00, cfg_i.debounce_ticks} + {1'b0, cfg_i.repeat_wait};
    reload  = ({1'b0, cfg_i.repeat_period} > rpt_sum) ? 9'd0
                : rpt_sum - {1'b0, cfg_i.repeat_period};

    cnt_d  = cnt_q;
    last_d = last_q;
    pend_d = pend_q;

    if (tick_i) begin
      if (key == 3'd0 || key != last_q) begin
        cnt_d  = 8'd0;
        last_d = key;
        pend_d = '0;
      end else begin
        cnt_d  = cnt_inc;
        pend_d = '{kind: swt_pkg::EVT_HELD, keys: key};
        if (cnt_inc == {1'b0, cfg_i.debounce_ticks}) begin
          pend_d.kind = swt_pkg::EVT_PRESS;
        end
        // a sum above 255 can never match the 8-bit counter
        if ({1'b0, cnt_inc} == rpt_sum) begin
          cnt_d       = reload[7:0];
          pend_d.kind = swt_pkg::EVT_REPEAT;
        end
      end
    end else if (consume_i) begin
      pend_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= '0;
      pend_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
      pend_q <= pend_d;
    end
  end

  assign pend_o = pend_q;

endmodule

### hw/rtl/stopwatch_timer_with_key_debounce_core.sv
// Stopwatch / countdown timer core with tick counter and key debounce.
// Top level; depends on swt_pkg and swt_debounce.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid_i/in_ready_o, opcode..run    | in
//   out     | out_valid_o/out_ready_i, hours..phase | out
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i       | in
//
// An accepted beat sits in the input register, is
// processed in one pass and lands in the result register. One beat per
// cycle when the output is drained every cycle. Input ready follows the
// result register: the input stage moves whenever the result register is
// empty or being taken. Reset clears the clock, counters and events.
module stopwatch_timer_with_key_debounce_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [swt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [swt_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   opcode_i,
  input  logic [2:0]                   key_pins_i,
  input  logic                         run_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [4:0]                   hours_o,
  output logic [5:0]                   minutes_o,
  output logic [5:0]                   seconds_o,
  output logic [6:0]                   hundredths_o,
  output logic                         running_o,
  output logic [15:0]                  tick_count_o,
  output logic [2:0]                   event_kind_o,
  output logic [2:0]                   event_keys_o,
  output logic [3:0]                   slowtick_phase_o
);

  // configuration
  logic              cnt_down_q;
  logic [4:0]        tgt_hrs_q;
  logic [5:0]        tgt_min_q;
  logic [5:0]        tgt_sec_q;
  logic [6:0]        tgt_hun_q;
  swt_pkg::key_cfg_t key_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_down_q              <= 1'b0;
      tgt_hrs_q               <= '0;
      tgt_min_q               <= '0;
      tgt_sec_q               <= '0;
      tgt_hun_q               <= '0;
      key_cfg_q.debounce_ticks <= swt_pkg::DEBOUNCE_RST;
      key_cfg_q.repeat_wait    <= swt_pkg::RPT_WAIT_RST;
      key_cfg_q.repeat_period  <= swt_pkg::RPT_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swt_pkg::REG_COUNT_DOWN: cnt_down_q <= cfg_data_i[0];
        swt_pkg::REG_TGT_HOURS:  tgt_hrs_q  <= cfg_data_i[4:0];
        swt_pkg::REG_TGT_MINS:   tgt_min_q  <= cfg_data_i[5:0];
        swt_pkg::REG_TGT_SECS:   tgt_sec_q  <= cfg_data_i[5:0];
        swt_pkg::REG_TGT_HUNDS:  tgt_hun_q  <= cfg_data_i[6:0];
        swt_pkg::REG_DEBOUNCE:   key_cfg_q.debounce_ticks <= cfg_data_i[6:0];
        swt_pkg::REG_RPT_WAIT:   key_cfg_q.repeat_wait    <= cfg_data_i;
        swt_pkg::REG_RPT_PERIOD: key_cfg_q.repeat_period  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  logic [1:0] s1_op_q;
  logic [2:0] s1_pins_q;
  logic       s1_run_q;
  logic       s1_go;

  assign s1_go      = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q   <= opcode_i;
      s1_pins_q <= key_pins_i;
      s1_run_q  <= run_value_i;
    end
  end

  // timekeeping state
  logic [4:0]  hrs_q, hrs_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [6:0]  hun_q, hun_d;
  logic        run_q, run_d;
  logic [15:0] tick_q, tick_d;
  logic [4:0]  slow_q, slow_d;   // bit 4 pending, bits 3:0 phase

  logic        is_tick, is_read;
  logic        key_take;
  swt_pkg::key_evt_t key_pend;

  logic [7:0] up_hun;
  logic [6:0] up_sec, up_min;
  logic [5:0] up_hrs;
  logic [2:0] evt_kind;
  logic [2:0] evt_keys;
  logic [3:0] evt_phase;

  assign is_tick  = s1_go && (s1_op_q == swt_pkg::OP_TICK);
  assign is_read  = s1_go && (s1_op_q == swt_pkg::OP_READ);
  assign key_take = is_read && (key_pend.kind != swt_pkg::EVT_NONE);

  swt_debounce u_debounce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (is_tick),
    .consume_i  (key_take),
    .key_pins_i (s1_pins_q),
    .cfg_i      (key_cfg_q),
    .pend_o     (key_pend)
  );

  always_comb begin
    // one spare bit so an out-of-range value still carries on >=
    up_hun = {1'b0, hun_q} + 8'd1;
    up_sec = {1'b0, sec_q} + 7'd1;
    up_min = {1'b0, min_q} + 7'd1;
    up_hrs = {1'b0, hrs_q} + 6'd1;

    hrs_d  = hrs_q;
    min_d  = min_q;
    sec_d  = sec_q;
    hun_d  = hun_q;
    run_d  = run_q;
    tick_d = tick_q;
    slow_d = slow_q;

    evt_kind  = swt_pkg::EVT_NONE;
    evt_keys  = 3'd0;
    evt_phase = 4'd0;

    if (s1_go) begin
      case (s1_op_q)
        swt_pkg::OP_TICK: begin
          if (run_q) begin
            if (!cnt_down_q) begin
              if (up_hun >= swt_pkg::HUNDS_LIM) begin
                hun_d = 7'd0;
                if (up_sec >= swt_pkg::SECS_LIM) begin
                  sec_d = 6'd0;
                  if (up_min >= swt_pkg::MINS_LIM) begin
                    min_d = 6'd0;
                    hrs_d = (up_hrs >= swt_pkg::HOURS_LIM) ? 5'd0 : up_hrs[4:0];
                  end else begin
                    min_d = up_min[5:0];
                  end
                end else begin
                  sec_d = up_sec[5:0];
                end
              end else begin
                hun_d = up_hun[6:0];
              end
              if (hrs_d == tgt_hrs_q && min_d == tgt_min_q &&
                  sec_d == tgt_sec_q && hun_d == tgt_hun_q) begin
                run_d = 1'b0;
              end
            end else begin
              if (hun_q == 7'd0) begin
                hun_d = swt_pkg::HUNDS_MAX;
                if (sec_q == 6'd0) begin
                  sec_d = swt_pkg::SECS_MAX;
                  if (min_q == 6'd0) begin
                    min_d = swt_pkg::MINS_MAX;
                    hrs_d = (hrs_q == 5'd0) ? swt_pkg::HOURS_MAX : hrs_q - 5'd1;
                  end else begin
                    min_d = min_q - 6'd1;
                  end
                end else begin
                  sec_d = sec_q - 6'd1;
                end
              end else begin
                hun_d = hun_q - 7'd1;
              end
              if ((|hrs_d) == 1'b0 && (|min_d) == 1'b0 &&
                  (|sec_d) == 1'b0 && (|hun_d) == 1'b0) begin
                run_d = 1'b0;
              end
            end
          end
          tick_d = tick_q + 16'd1;
          if (tick_d[3:0] == 4'd0) begin
            slow_d = {1'b1, tick_d[7:4]};
          end
        end
        swt_pkg::OP_READ: begin
          // a key event wins; the slowtick then stays pending
          if (key_take) begin
            evt_kind = key_pend.kind;
            evt_keys = key_pend.keys;
          end else if (slow_q[4]) begin
            evt_kind  = swt_pkg::EVT_SLOW;
            evt_phase = slow_q[3:0];
            slow_d    = 5'd0;
          end
        end
        swt_pkg::OP_LOAD: begin
          run_d = 1'b0;
          if (cnt_down_q) begin
            hrs_d = tgt_hrs_q;
            min_d = tgt_min_q;
            sec_d = tgt_sec_q;
            hun_d = tgt_hun_q;
          end else begin
            hrs_d = 5'd0;
            min_d = 6'd0;
            sec_d = 6'd0;
            hun_d = 7'd0;
          end
        end
        swt_pkg::OP_RUN: begin
          run_d = s1_run_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hrs_q  <= '0;
      min_q  <= '0;
      sec_q  <= '0;
      hun_q  <= '0;
      run_q  <= 1'b0;
      tick_q <= '0;
      slow_q <= '0;
    end else begin
      hrs_q  <= hrs_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
      hun_q  <= hun_d;
      run_q  <= run_d;
      tick_q <= tick_d;
      slow_q <= slow_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_go) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      hours_o          <= hrs_d;
      minutes_o        <= min_d;
      seconds_o        <= sec_d;
      hundredths_o     <= hun_d;
      running_o        <= run_d;
      tick_count_o     <= tick_d;
      event_kind_o     <= evt_kind;
      event_keys_o     <= evt_keys;
      slowtick_phase_o <= evt_phase;
    end
  end

endmodule
